// ===== rtl/tks_pkg.sv =====
// Package for the top-k selector: payload types, entry type, command and status
// structs, and the ranking function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tks_pkg;

    localparam int DEF_MAX_KEEP = 64;
    localparam int KC_W         = 7;
    localparam int CFG_IDX_W    = 1;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_SMALLEST = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT    = 1'd1;

    // Opcodes of an input transaction.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [31:0]        item_id;
        logic signed [31:0] key;
        logic [31:0]        sub_id;
        logic signed [63:0] code;
        logic signed [31:0] dist_a;
        logic signed [31:0] dist_b;
    } t_in_item;

    typedef struct packed {
        logic               accepted;
        logic [31:0]        out_item_id;
        logic signed [31:0] out_key;
        logic [31:0]        out_sub_id;
        logic signed [63:0] out_code;
        logic signed [31:0] out_dist_a;
        logic signed [31:0] out_dist_b;
        logic               last;
    } t_out_item;

    // One stored candidate with its arrival stamp.
    typedef struct packed {
        logic signed [31:0] key;
        logic [31:0]        item_id;
        logic [31:0]        sub_id;
        logic signed [63:0] code;
        logic signed [31:0] dist_a;
        logic signed [31:0] dist_b;
        logic [31:0]        stamp;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;      // capture the input transaction
        logic clr_best;   // restart the running best/worst search
        logic rd_en;      // read one stored entry
        logic scan_worst; // search for the worst entry instead of the best
        logic wr_fill;    // write the input at slot held_count and grow the store
        logic wr_repl;    // overwrite the worst entry found
        logic arr_inc;    // advance the arrival counter
        logic clr_emit;   // clear the emitted marks
        logic mark_emit;  // mark the best entry found as emitted
        logic out_ins;    // present an insert result
        logic out_acc;    // accepted flag of that insert result
        logic out_rd;     // present the best entry found
        logic out_empty;  // present an empty readout result
        logic out_last;   // last flag of a readout result
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_read;    // the latched transaction is a readout
        logic count_lt_k; // store not yet full
        logic repl_ok;    // new key may replace the worst entry
    } t_dp_sts;

    // Strict key order under the selected direction.
    function automatic logic f_key_better(logic keep_small, logic signed [31:0] a,
                                          logic signed [31:0] b);
        f_key_better = keep_small ? (a < b) : (a > b);
    endfunction

    // True when entry a in slot sa ranks ahead of entry b in slot sb.
    function automatic logic f_better(logic keep_small, t_entry a, logic [KC_W-1:0] sa,
                                      t_entry b, logic [KC_W-1:0] sb);
        logic res;
        if (f_key_better(keep_small, a.key, b.key)) begin
            res = 1'b1;
        end else if (f_key_better(keep_small, b.key, a.key)) begin
            res = 1'b0;
        end else if (a.stamp != b.stamp) begin
            res = a.stamp < b.stamp;
        end else begin
            res = sa < sb;
        end
        f_better = res;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/top_k_selector_top.sv =====
// Top level of the top-k selector: joins the controller and the datapath (tks_pkg).
// An insert that finds the store not full writes its entry at once; a full-store insert
// first scans the store one entry per cycle for the worst entry. A readout rescans the
// store for each result it gives, best first; an empty readout gives a single empty
// result. One transaction at a time; results cannot be stalled.
// Reset clears the store, the arrival counter and sets keep_smallest = 1, keep_count = 64.
`timescale 1ns / 1ps
`default_nettype none
module top_k_selector_top #(
    parameter int MAX_KEEP = tks_pkg::DEF_MAX_KEEP
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             start,
    input  wire tks_pkg::t_in_item          i_item,
    output logic                            busy,
    output logic                            o_valid,
    output tks_pkg::t_out_item              o_result,
    input  wire                             i_cfg_we,
    input  wire [tks_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [tks_pkg::KC_W-1:0]         i_cfg_data
);
    import tks_pkg::*;

    localparam int IW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int CW = $clog2(MAX_KEEP + 1);

    t_dp_cmd       cmd;
    t_dp_sts       sts;
    logic [IW-1:0] rd_addr;
    logic [CW-1:0] count;
    logic [CW-1:0] emit_n;

    tks_ctrl #(.MAX_KEEP(MAX_KEEP), .IW(IW), .CW(CW)) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_sts    (sts),
        .i_count  (count),
        .i_emit_n (emit_n),
        .o_cmd    (cmd),
        .o_rd_addr(rd_addr),
        .busy     (busy)
    );

    tks_dp #(.MAX_KEEP(MAX_KEEP), .IW(IW), .CW(CW)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_cmd     (cmd),
        .i_rd_addr (rd_addr),
        .o_sts     (sts),
        .o_count   (count),
        .o_emit_n  (emit_n),
        .o_valid   (o_valid),
        .o_result  (o_result)
    );

endmodule
`default_nettype wire

// ===== rtl/tks_dp.sv =====
// Datapath of the top-k selector: entry memory, configuration registers,
// counters, search registers and result register. Depends on tks_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tks_dp #(
    parameter int MAX_KEEP = tks_pkg::DEF_MAX_KEEP,
    parameter int IW       = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1,
    parameter int CW       = $clog2(MAX_KEEP + 1)
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire tks_pkg::t_in_item          i_item,
    input  wire                             i_cfg_we,
    input  wire [tks_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [tks_pkg::KC_W-1:0]         i_cfg_data,
    input  wire tks_pkg::t_dp_cmd           i_cmd,
    input  wire [IW-1:0]                    i_rd_addr,
    output tks_pkg::t_dp_sts                o_sts,
    output logic [CW-1:0]                   o_count,
    output logic [CW-1:0]                   o_emit_n,
    output logic                            o_valid,
    output tks_pkg::t_out_item              o_result
);
    import tks_pkg::*;

    logic               r_keep_smallest;
    logic [KC_W-1:0]    r_keep_count;
    logic [CW-1:0]      r_count;
    logic [31:0]        r_arrival;
    t_in_item           r_in;
    t_entry             r_mem [MAX_KEEP];
    t_entry             r_rd_data;
    logic               r_rd_vld;
    logic [IW-1:0]      r_rd_idx;
    t_entry             r_best;
    logic [IW-1:0]      r_best_slot;
    logic               r_have;
    logic [MAX_KEEP-1:0] r_emitted;
    logic               r_valid;
    t_out_item          r_result;

    logic [CW-1:0]      k_eff;
    t_entry             wr_entry;
    logic               take;

    // Effective keep count, clamped to 1..MAX_KEEP.
    always_comb begin
        if (r_keep_count == '0) begin
            k_eff = CW'(1);
        end else if (r_keep_count > KC_W'(MAX_KEEP)) begin
            k_eff = CW'(MAX_KEEP);
        end else begin
            k_eff = r_keep_count[CW-1:0];
        end
    end

    assign o_count  = r_count;
    assign o_emit_n = (r_count < k_eff) ? r_count : k_eff;
    assign o_sts.is_read    = (r_in.opcode == OP_READ);
    assign o_sts.count_lt_k = (r_count < k_eff);
    assign o_sts.repl_ok    = !f_key_better(r_keep_smallest, r_best.key, r_in.key);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_smallest <= 1'b1;
            r_keep_count    <= KC_W'(64);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_KEEP_SMALLEST: r_keep_smallest <= i_cfg_data[0];
                REG_KEEP_COUNT:    r_keep_count    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_in <= i_item;
        end
    end

    // Fill count and arrival counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_arrival <= '0;
        end else begin
            if (i_cmd.wr_fill) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.arr_inc) begin
                r_arrival <= r_arrival + 32'd1;
            end
        end
    end

    always_comb begin
        wr_entry.key     = r_in.key;
        wr_entry.item_id = r_in.item_id;
        wr_entry.sub_id  = r_in.sub_id;
        wr_entry.code    = r_in.code;
        wr_entry.dist_a  = r_in.dist_a;
        wr_entry.dist_b  = r_in.dist_b;
        wr_entry.stamp   = r_arrival;
    end

    // Entry memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_fill) begin
            r_mem[r_count[IW-1:0]] <= wr_entry;
        end else if (i_cmd.wr_repl) begin
            r_mem[r_best_slot] <= wr_entry;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_idx  <= i_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
        end
    end

    // Running search: worst entry for a replacement, best unemitted one for readout.
    always_comb begin
        if (i_cmd.scan_worst) begin
            take = !r_have || f_better(r_keep_smallest, r_best, KC_W'(r_best_slot),
                                       r_rd_data, KC_W'(r_rd_idx));
        end else begin
            take = !r_emitted[r_rd_idx] &&
                   (!r_have || f_better(r_keep_smallest, r_rd_data, KC_W'(r_rd_idx),
                                        r_best, KC_W'(r_best_slot)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_cmd.clr_best) begin
            r_have <= 1'b0;
        end else if (r_rd_vld && take) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld && take && !i_cmd.clr_best) begin
            r_best      <= r_rd_data;
            r_best_slot <= r_rd_idx;
        end
    end

    // Marks of entries already sent in this readout.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emitted <= '0;
        end else if (i_cmd.clr_emit) begin
            r_emitted <= '0;
        end else if (i_cmd.mark_emit) begin
            r_emitted[r_best_slot] <= 1'b1;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.out_ins || i_cmd.out_rd || i_cmd.out_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_rd) begin
            r_result.accepted    <= 1'b1;
            r_result.out_item_id <= r_best.item_id;
            r_result.out_key     <= r_best.key;
            r_result.out_sub_id  <= r_best.sub_id;
            r_result.out_code    <= r_best.code;
            r_result.out_dist_a  <= r_best.dist_a;
            r_result.out_dist_b  <= r_best.dist_b;
            r_result.last        <= i_cmd.out_last;
        end else if (i_cmd.out_ins || i_cmd.out_empty) begin
            r_result <= '{accepted: i_cmd.out_ins && i_cmd.out_acc, last: 1'b1,
                          default: '0};
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
`default_nettype wire

// ===== rtl/tks_ctrl.sv =====
// Controller of the top-k selector: sequences inserts, worst-entry scans and
// best-first readout scans. Depends on tks_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tks_ctrl #(
    parameter int MAX_KEEP = tks_pkg::DEF_MAX_KEEP,
    parameter int IW       = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1,
    parameter int CW       = $clog2(MAX_KEEP + 1)
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   start,
    input  wire tks_pkg::t_dp_sts i_sts,
    input  wire [CW-1:0]          i_count,
    input  wire [CW-1:0]          i_emit_n,
    output tks_pkg::t_dp_cmd      o_cmd,
    output logic [IW-1:0]         o_rd_addr,
    output logic                  busy
);
    import tks_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CHK     = 3'd1;
    localparam logic [2:0] S_INS_SCN = 3'd2;
    localparam logic [2:0] S_INS_WT  = 3'd3;
    localparam logic [2:0] S_INS_DEC = 3'd4;
    localparam logic [2:0] S_RD_SCN  = 3'd5;
    localparam logic [2:0] S_RD_WT   = 3'd6;
    localparam logic [2:0] S_RD_EMIT = 3'd7;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_emit_cnt, n_emit_cnt;
    logic          scan_end, emit_last;

    assign scan_end  = (r_idx + CW'(1) == i_count);
    assign emit_last = (r_emit_cnt + CW'(1) == i_emit_n);
    assign o_rd_addr = r_idx[IW-1:0];
    assign busy      = (r_state != S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_emit_cnt = r_emit_cnt;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_CHK;
                end
            end
            S_CHK: begin
                n_idx       = '0;
                o_cmd.clr_best = 1'b1;
                if (i_sts.is_read) begin
                    o_cmd.clr_emit = 1'b1;
                    n_emit_cnt     = '0;
                    if (i_emit_n == '0) begin
                        o_cmd.out_empty = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        n_state = S_RD_SCN;
                    end
                end else if (i_sts.count_lt_k) begin
                    o_cmd.wr_fill = 1'b1;
                    o_cmd.arr_inc = 1'b1;
                    o_cmd.out_ins = 1'b1;
                    o_cmd.out_acc = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    n_state = S_INS_SCN;
                end
            end
            S_INS_SCN: begin
                o_cmd.rd_en      = 1'b1;
                o_cmd.scan_worst = 1'b1;
                n_idx            = r_idx + CW'(1);
                if (scan_end) begin
                    n_state = S_INS_WT;
                end
            end
            S_INS_WT: begin
                o_cmd.scan_worst = 1'b1;
                n_state          = S_INS_DEC;
            end
            S_INS_DEC: begin
                o_cmd.scan_worst = 1'b1;
                o_cmd.wr_repl    = i_sts.repl_ok;
                o_cmd.arr_inc    = 1'b1;
                o_cmd.out_ins    = 1'b1;
                o_cmd.out_acc    = i_sts.repl_ok;
                n_state          = S_IDLE;
            end
            S_RD_SCN: begin
                o_cmd.rd_en = 1'b1;
                n_idx       = r_idx + CW'(1);
                if (scan_end) begin
                    n_state = S_RD_WT;
                end
            end
            S_RD_WT: begin
                n_state = S_RD_EMIT;
            end
            S_RD_EMIT: begin
                o_cmd.out_rd    = 1'b1;
                o_cmd.out_last  = emit_last;
                o_cmd.mark_emit = 1'b1;
                o_cmd.clr_best  = 1'b1;
                n_idx           = '0;
                n_emit_cnt      = r_emit_cnt + CW'(1);
                n_state         = emit_last ? S_IDLE : S_RD_SCN;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_emit_cnt <= '0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_emit_cnt <= n_emit_cnt;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/tks_checker.sv =====
// Port-level checker for the top-k selector and its bind to the top level.
// Depends on tks_pkg and top_k_selector_top.
`timescale 1ns / 1ps
`default_nettype none
module tks_checker (
    input wire                     i_clk,
    input wire                     i_rst_n,
    input wire                     start,
    input wire                     busy,
    input wire                     o_valid,
    input wire tks_pkg::t_out_item o_result
);
    import tks_pkg::*;

    // An accepted transaction keeps the block busy in the next cycle.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not make the block busy");

    // A result that is not the last one is followed by more work.
    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.last |-> busy)
        else $error("non-final result while idle");

    // The block goes idle exactly as the final result of a transaction shows.
    a_idle_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid && o_result.last)
        else $error("block went idle without a final result");

    // Every result comes from a transaction that was in progress in the cycle before.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a transaction in progress");

endmodule

bind top_k_selector_top tks_checker u_tks_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid),
    .o_result(o_result)
);
`default_nettype wire
